// ----- design/assert_macros.svh -----
// Assertion macros used by the reassembler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same clock edge.
`define CSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the clock edge after the antecedent.
`define CSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/csr_pkg.sv -----
// Shared types, codes and the CRC step function of the chunked stream reassembler.
package csr_pkg;

    localparam int WP_W          = 14;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int BEGIN_MIN_LEN = 6;
    localparam int HDR_MIN_LEN   = 3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [2:0] OP_BEGIN   = 3'd0;
    localparam logic [2:0] OP_HDR     = 3'd1;
    localparam logic [2:0] OP_DATA    = 3'd2;
    localparam logic [2:0] OP_END     = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;
    localparam logic [2:0] OP_RESET   = 3'd6;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_BAD_PARAMS  = 4'd2,
        ST_INACTIVE    = 4'd3,
        ST_INDEX_RANGE = 4'd4,
        ST_LEN_RANGE   = 4'd5,
        ST_FRAME_SHORT = 4'd6,
        ST_PAST_END    = 4'd7,
        ST_MISSING     = 4'd8,
        ST_SIZE_MISM   = 4'd9,
        ST_CRC_MISM    = 4'd10,
        ST_NOT_READY   = 4'd11,
        ST_UNEXPECTED  = 4'd12
    } t_status;

    typedef enum logic [2:0] {
        K_BEGIN, K_HDR, K_DATA, K_END, K_READ, K_RELEASE, K_RESET, K_BAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        begin_short;
        logic        begin_bad;
        logic        hdr_short;
        logic        idx_over;
        logic        len_bad;
        logic        frame_short;
        logic        rd_over;
        logic [15:0] file_size;
        logic [7:0]  chunk_count;
        logic [15:0] crc_target;
        logic [7:0]  chunk_index;
        logic [7:0]  chunk_length;
        logic [7:0]  data_byte;
        logic [13:0] read_address;
    } t_req;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                                input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/csr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csr_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/csr_front.sv -----
// Front end: accepts requests, decodes and pre-checks them, and queues them for the back end.
module csr_front import csr_pkg::*; #(
    parameter int MAX_BYTES   = 16384,
    parameter int MAX_CHUNKS  = 128,
    parameter int CHUNK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [8:0]  i_payload_length,
    input  logic [15:0] i_file_size,
    input  logic [7:0]  i_chunk_count,
    input  logic [15:0] i_crc_target,
    input  logic [7:0]  i_chunk_index,
    input  logic [7:0]  i_chunk_length,
    input  logic [7:0]  i_data_byte,
    input  logic [13:0] i_read_address,
    output logic        o_q_valid,
    output t_req        o_req,
    input  logic        i_pop
);

    t_req           r_q [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    t_req           n_req;
    logic           push;

    always_comb begin
        n_req = '0;
        case (i_op)
            OP_BEGIN:   n_req.kind = K_BEGIN;
            OP_HDR:     n_req.kind = K_HDR;
            OP_DATA:    n_req.kind = K_DATA;
            OP_END:     n_req.kind = K_END;
            OP_READ:    n_req.kind = K_READ;
            OP_RELEASE: n_req.kind = K_RELEASE;
            OP_RESET:   n_req.kind = K_RESET;
            default:    n_req.kind = K_BAD;
        endcase
        n_req.begin_short  = i_payload_length < 9'(BEGIN_MIN_LEN);
        n_req.begin_bad    = (i_file_size == 16'd0)
                          || ({1'b0, i_file_size} > 17'(MAX_BYTES))
                          || (i_chunk_count == 8'd0)
                          || ({1'b0, i_chunk_count} > 9'(MAX_CHUNKS));
        n_req.hdr_short    = i_payload_length < 9'(HDR_MIN_LEN);
        n_req.idx_over     = {1'b0, i_chunk_index} >= 9'(MAX_CHUNKS);
        n_req.len_bad      = {1'b0, i_chunk_length} > 9'(CHUNK_BYTES);
        n_req.frame_short  = (10'(i_chunk_length) + 10'(HDR_MIN_LEN))
                          > {1'b0, i_payload_length};
        n_req.rd_over      = {3'b000, i_read_address} >= 17'(MAX_BYTES);
        n_req.file_size    = i_file_size;
        n_req.chunk_count  = i_chunk_count;
        n_req.crc_target   = i_crc_target;
        n_req.chunk_index  = i_chunk_index;
        n_req.chunk_length = i_chunk_length;
        n_req.data_byte    = i_data_byte;
        n_req.read_address = i_read_address;
    end

    assign o_stall   = (r_cnt == (QAW+1)'(QDEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_req     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wr] <= n_req;
                r_wr      <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/csr_back.sv -----
// Back end: executes queued requests against the stream state and the file buffer.
module csr_back import csr_pkg::*; #(
    parameter int MAX_BYTES   = 16384,
    parameter int MAX_CHUNKS  = 128,
    parameter int CHUNK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_req        i_req,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic        o_ready_res,
    output logic        o_all_chunks,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_buffer_size,
    output logic [15:0] o_received_count
);

    localparam int AW   = $clog2(MAX_BYTES);
    localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int MAPN = 1 << CW;

    typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_CRC, S_READ} t_state;

    t_state          r_state;
    logic [MAPN-1:0] r_map;
    logic [15:0]     r_psize;
    logic [7:0]      r_pchunks;
    logic [15:0]     r_ecrc;
    logic [15:0]     r_bytes;
    logic [7:0]      r_seen;
    logic            r_active;
    logic            r_ready;
    logic [15:0]     r_wp;
    logic [7:0]      r_rem;
    logic [15:0]     r_cnt;
    logic            r_dv;
    logic [15:0]     r_crc;
    logic            r_ov;
    t_status         r_status;
    logic [7:0]      r_rdata;
    logic [15:0]     r_ccrc;
    logic [15:0]     r_bsize;

    logic            out_free;
    logic            ld;
    t_status         ld_status;
    logic [7:0]      ld_rdata;
    logic [15:0]     ld_ccrc;
    logic [15:0]     ld_bsize;
    logic            clr;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic [15:0]     hdr_offset;
    logic [16:0]     hdr_end;
    t_status         hdr_status;
    logic            seen_bit;
    logic            data_ok;
    logic            wp_in_range;
    logic            crc_fin;

    csr_ram #(.W(8), .D(MAX_BYTES)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_ov || !i_stall;
    assign o_pop       = (r_state == S_IDLE) && i_q_valid && out_free;
    assign hdr_offset  = 16'(i_req.chunk_index) * 16'(CHUNK_BYTES);
    assign hdr_end     = {1'b0, hdr_offset} + 17'(i_req.chunk_length);
    assign seen_bit    = r_map[i_req.chunk_index[CW-1:0]];
    assign data_ok     = r_active && (r_rem != 8'd0);
    assign wp_in_range = {1'b0, r_wp} < 17'(MAX_BYTES);
    assign crc_fin     = (r_cnt == r_psize) && !r_dv;

    always_comb begin
        if (!r_active) begin
            hdr_status = ST_INACTIVE;
        end else if (i_req.hdr_short) begin
            hdr_status = ST_SHORT;
        end else if (i_req.chunk_index >= r_pchunks || i_req.idx_over) begin
            hdr_status = ST_INDEX_RANGE;
        end else if (i_req.len_bad) begin
            hdr_status = ST_LEN_RANGE;
        end else if (i_req.frame_short) begin
            hdr_status = ST_FRAME_SHORT;
        end else if (hdr_end > {1'b0, r_psize}) begin
            hdr_status = ST_PAST_END;
        end else begin
            hdr_status = ST_OK;
        end
    end

    always_comb begin
        ld        = 1'b0;
        ld_status = ST_OK;
        ld_rdata  = 8'd0;
        ld_ccrc   = 16'd0;
        ld_bsize  = 16'd0;
        clr       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_wp);
        ram_wdata = i_req.data_byte;
        ram_raddr = AW'(i_req.read_address);
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_req.kind)
                        K_BEGIN: begin
                            if (i_req.begin_short) begin
                                ld        = 1'b1;
                                ld_status = ST_SHORT;
                            end else if (i_req.begin_bad) begin
                                ld        = 1'b1;
                                ld_status = ST_BAD_PARAMS;
                            end
                        end
                        K_HDR: begin
                            ld        = 1'b1;
                            ld_status = hdr_status;
                        end
                        K_DATA: begin
                            ld        = 1'b1;
                            ld_status = data_ok ? ST_OK : ST_UNEXPECTED;
                            ram_we    = data_ok && wp_in_range;
                        end
                        K_END: begin
                            if (!r_active) begin
                                ld        = 1'b1;
                                ld_status = ST_INACTIVE;
                            end else if (r_seen != r_pchunks) begin
                                ld        = 1'b1;
                                ld_status = ST_MISSING;
                                clr       = 1'b1;
                            end else if (r_bytes != r_psize) begin
                                ld        = 1'b1;
                                ld_status = ST_SIZE_MISM;
                                clr       = 1'b1;
                            end
                        end
                        K_READ: begin
                            if (!r_ready) begin
                                ld        = 1'b1;
                                ld_status = ST_NOT_READY;
                            end else if ({2'b00, i_req.read_address} >= r_psize
                                         || i_req.rd_over) begin
                                ld        = 1'b1;
                                ld_status = ST_PAST_END;
                            end
                        end
                        K_RELEASE: begin
                            ld = 1'b1;
                            if (!r_ready) begin
                                ld_status = ST_NOT_READY;
                            end else begin
                                ld_bsize = r_psize;
                                clr      = 1'b1;
                            end
                        end
                        K_RESET: begin
                            ld  = 1'b1;
                            clr = 1'b1;
                        end
                        default: begin
                            ld        = 1'b1;
                            ld_status = ST_BAD_PARAMS;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cnt);
                ram_wdata = 8'd0;
                ld        = (r_cnt == r_psize - 16'd1);
            end
            S_CRC: begin
                ram_raddr = AW'(r_cnt);
                if (crc_fin) begin
                    ld      = 1'b1;
                    ld_ccrc = r_crc;
                    if (r_crc != r_ecrc) begin
                        ld_status = ST_CRC_MISM;
                        clr       = 1'b1;
                    end
                end
            end
            S_READ: begin
                ld       = 1'b1;
                ld_rdata = ram_rdata;
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_map     <= '0;
            r_psize   <= '0;
            r_pchunks <= '0;
            r_ecrc    <= '0;
            r_bytes   <= '0;
            r_seen    <= '0;
            r_active  <= 1'b0;
            r_ready   <= 1'b0;
            r_wp      <= '0;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_dv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (ld) begin
                r_ov     <= 1'b1;
                r_status <= ld_status;
                r_rdata  <= ld_rdata;
                r_ccrc   <= ld_ccrc;
                r_bsize  <= ld_bsize;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_req.kind)
                            K_BEGIN: begin
                                if (!i_req.begin_short && !i_req.begin_bad) begin
                                    r_map     <= '0;
                                    r_bytes   <= '0;
                                    r_seen    <= '0;
                                    r_ready   <= 1'b0;
                                    r_wp      <= '0;
                                    r_rem     <= '0;
                                    r_psize   <= i_req.file_size;
                                    r_pchunks <= i_req.chunk_count;
                                    r_ecrc    <= i_req.crc_target;
                                    r_active  <= 1'b1;
                                    r_cnt     <= '0;
                                    r_state   <= S_CLEAR;
                                end
                            end
                            K_HDR: begin
                                r_rem <= '0;
                                if (hdr_status == ST_OK) begin
                                    r_wp  <= hdr_offset;
                                    r_rem <= i_req.chunk_length;
                                    if (!seen_bit) begin
                                        r_map[i_req.chunk_index[CW-1:0]] <= 1'b1;
                                        r_seen  <= r_seen + 8'd1;
                                        r_bytes <= r_bytes + 16'(i_req.chunk_length);
                                    end
                                end
                            end
                            K_DATA: begin
                                if (data_ok) begin
                                    r_wp  <= 16'({r_wp[WP_W-1:0] + WP_W'(1)});
                                    r_rem <= r_rem - 8'd1;
                                end
                            end
                            K_END: begin
                                r_rem <= '0;
                                if (r_active && r_seen == r_pchunks
                                    && r_bytes == r_psize) begin
                                    r_cnt   <= '0;
                                    r_dv    <= 1'b0;
                                    r_crc   <= CRC_INIT;
                                    r_state <= S_CRC;
                                end
                            end
                            K_READ: begin
                                if (r_ready && {2'b00, i_req.read_address} < r_psize
                                    && !i_req.rd_over) begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 16'd1;
                    if (ld) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CRC: begin
                    if (r_dv) begin
                        r_crc <= crc16_byte(r_crc, ram_rdata);
                    end
                    if (r_cnt != r_psize) begin
                        r_cnt <= r_cnt + 16'd1;
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (crc_fin) begin
                        r_state <= S_IDLE;
                        if (r_crc == r_ecrc) begin
                            r_ready  <= 1'b1;
                            r_active <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (clr) begin
                r_map     <= '0;
                r_psize   <= '0;
                r_pchunks <= '0;
                r_ecrc    <= '0;
                r_bytes   <= '0;
                r_seen    <= '0;
                r_active  <= 1'b0;
                r_ready   <= 1'b0;
                r_wp      <= '0;
                r_rem     <= '0;
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_status;
    assign o_read_data      = r_rdata;
    assign o_computed_crc   = r_ccrc;
    assign o_buffer_size    = r_bsize;
    assign o_ready_res      = r_ready;
    assign o_all_chunks     = (r_pchunks != 8'd0) && (r_seen == r_pchunks);
    assign o_received_count = r_bytes;

endmodule

// ----- design/chunked_stream_reassembler.sv -----
// Top level of the chunked stream reassembler: front queue, back end and checks.
// Header, data, release, reset and rejected requests finish as they are popped; a read passes through a read state.
// An accepted begin walks the buffer to zero its first file-size bytes before it reports.
// An end that reaches the CRC check walks the first file-size bytes of the buffer once.
// Data bytes sustain one request per cycle while no result is stalled; requests pass a 4-entry queue.
// Synchronous active-low reset empties the queue and clears all stream state; the buffer is not.
module chunked_stream_reassembler import csr_pkg::*; #(
    parameter int MAX_BYTES   = 16384,
    parameter int MAX_CHUNKS  = 128,
    parameter int CHUNK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [8:0]  i_payload_length,
    input  logic [15:0] i_file_size,
    input  logic [7:0]  i_chunk_count,
    input  logic [15:0] i_crc_target,
    input  logic [7:0]  i_chunk_index,
    input  logic [7:0]  i_chunk_length,
    input  logic [7:0]  i_data_byte,
    input  logic [13:0] i_read_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic        o_ready_res,
    output logic        o_all_chunks,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_buffer_size,
    output logic [15:0] o_received_count
);

`include "assert_macros.svh"

    // The front end decodes each request and settles every check that does not
    // depend on stream state, so the back end only compares against its registers.
    logic q_valid;
    logic q_pop;
    t_req q_req;

    csr_front #(
        .MAX_BYTES   (MAX_BYTES),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_payload_length (i_payload_length),
        .i_file_size      (i_file_size),
        .i_chunk_count    (i_chunk_count),
        .i_crc_target     (i_crc_target),
        .i_chunk_index    (i_chunk_index),
        .i_chunk_length   (i_chunk_length),
        .i_data_byte      (i_data_byte),
        .i_read_address   (i_read_address),
        .o_q_valid        (q_valid),
        .o_req            (q_req),
        .i_pop            (q_pop)
    );

    // The back end pops a request only when its output register is free, so a
    // result never waits inside a long buffer walk; while a result is stalled
    // the back end is idle and the state-derived outputs stay put.
    csr_back #(
        .MAX_BYTES   (MAX_BYTES),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_req            (q_req),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_ready_res      (o_ready_res),
        .o_all_chunks     (o_all_chunks),
        .o_read_data      (o_read_data),
        .o_computed_crc   (o_computed_crc),
        .o_buffer_size    (o_buffer_size),
        .o_received_count (o_received_count)
    );

    // Only an end that reached the CRC check reports a computed CRC.
    `CSR_ASSERT_IMP(a_crc_only_on_check, o_valid && o_status != ST_OK, o_computed_crc == 16'd0 || o_status == ST_CRC_MISM, "CRC reported on a failed non-CRC request")
    // A release that hands over a file leaves no verified file behind.
    `CSR_ASSERT_IMP(a_release_clears, o_valid && o_buffer_size != 16'd0, o_status == ST_OK && !o_ready_res, "release did not clear the stream")
    // A verified file always has a nonzero byte count.
    `CSR_ASSERT_IMP(a_ready_has_bytes, o_valid && o_ready_res, o_received_count != 16'd0, "verified file with zero bytes")
    // Stream state must not move while a result is held.
    `CSR_ASSERT_NXT(a_state_frozen, o_valid && i_stall, $stable(o_ready_res) && $stable(o_received_count), "stream state changed under a stalled result")

endmodule
